// ===== rtl/qte_pkg.sv =====
// Shared types, widths and constant tables of the quaternion to Euler block.
`timescale 1ns / 1ps
package qte_pkg;
    localparam int QW          = 32;  // input component
    localparam int NW          = 31;  // normalised component
    localparam int AW          = 30;  // angle field
    localparam int CW          = 42;  // CORDIC argument
    localparam int ZW          = 34;  // CORDIC angle accumulator, Q30 radians
    localparam int DIV_STEPS   = 31;
    localparam int SQRT_STEPS  = 31;
    localparam int QUEUE_DEPTH = 4;

    localparam logic signed [ZW-1:0] PI_Q30      = ZW'(64'd3373259426);
    localparam logic signed [30:0]   RAD2DEG_Q24 = 31'(961263669);

    typedef struct packed {
        logic signed [QW-1:0] w;
        logic signed [QW-1:0] x;
        logic signed [QW-1:0] y;
        logic signed [QW-1:0] z;
        logic [1:0]           rsh;
        logic [4:0]           lsh;
        logic                 zero;
    } t_qte_entry;

    // arctan(2^-i) in Q30, truncated
    function automatic logic signed [ZW-1:0] atan_q30(input int i);
        case (i)
            0:  return ZW'(843314856);
            1:  return ZW'(497837829);
            2:  return ZW'(263043836);
            3:  return ZW'(133525158);
            4:  return ZW'(67021686);
            5:  return ZW'(33543515);
            6:  return ZW'(16775850);
            7:  return ZW'(8388437);
            8:  return ZW'(4194282);
            9:  return ZW'(2097149);
            10: return ZW'(1048575);
            11: return ZW'(524287);
            12: return ZW'(262143);
            13: return ZW'(131071);
            14: return ZW'(65535);
            15: return ZW'(32767);
            16: return ZW'(16383);
            17: return ZW'(8191);
            18: return ZW'(4095);
            19: return ZW'(2047);
            20: return ZW'(1023);
            21: return ZW'(511);
            22: return ZW'(255);
            23: return ZW'(127);
            24: return ZW'(63);
            25: return ZW'(31);
            26: return ZW'(15);
            27: return ZW'(7);
            28: return ZW'(3);
            29: return ZW'(1);
            default: return '0;
        endcase
    endfunction
endpackage

// ===== rtl/qte_quat_if.sv =====
// Valid/ready channel carrying one quaternion word.
`timescale 1ns / 1ps
interface qte_quat_if;
    import qte_pkg::*;
    logic                 valid;
    logic                 ready;
    logic signed [QW-1:0] quat_w;
    logic signed [QW-1:0] quat_x;
    logic signed [QW-1:0] quat_y;
    logic signed [QW-1:0] quat_z;
    modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
    modport sink (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

// ===== rtl/qte_euler_if.sv =====
// Valid/ready channel carrying one Euler angle word.
`timescale 1ns / 1ps
interface qte_euler_if;
    import qte_pkg::*;
    logic                 valid;
    logic                 ready;
    logic signed [AW-1:0] roll_angle;
    logic signed [AW-1:0] pitch_angle;
    logic signed [AW-1:0] yaw_angle;
    logic                 zero_quaternion;
    modport source (output valid, roll_angle, pitch_angle, yaw_angle, zero_quaternion,
                    input ready);
    modport sink (input valid, roll_angle, pitch_angle, yaw_angle, zero_quaternion,
                  output ready);
endinterface

// ===== rtl/quaternion_to_euler.sv =====
// Top level: quaternion to roll, pitch and yaw angles.
`timescale 1ns / 1ps
// Usage
//   i_quat  : valid/ready channel, one quaternion word (w, x, y, z, signed Q30).
//   o_euler : valid/ready channel, one word of roll, pitch, yaw (Q of
//             ANGLE_FRAC_BITS) and the zero-quaternion flag.
//   i_cfg_wr_en / i_cfg_wr_data : angle unit, 0 radians (-pi..pi), 1 degrees
//             (0..360). Write only while no word is in flight.
// Throughput: one word per cycle while o_euler.ready is high.
// The pitch path is the longest: a 31-stage divider for the sine, a 31-stage
//   square root for the cosine, then a CORDIC of CORDIC_STEPS + 1 stages;
//   roll and yaw are delayed to match.
// A four-word queue parts the input register from the arithmetic pipeline,
// so input stays open while the output is held; a stalled output freezes the
// whole pipeline and, once the queue fills, drops i_quat.ready.
// Reset (i_rst_n low, synchronous) empties the queue and pipeline and selects
// radians.
module quaternion_to_euler #(
    parameter int ANGLE_FRAC_BITS = 20,
    parameter int CORDIC_STEPS    = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    qte_quat_if.sink    i_quat,
    qte_euler_if.source o_euler,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_wr_data
);
    import qte_pkg::*;

    t_qte_entry fq_entry;
    t_qte_entry qb_entry;
    logic       fq_push;
    logic       fq_full;
    logic       qb_pop;
    logic       qb_empty;
    logic       r_deg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deg <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_deg <= i_cfg_wr_data;
        end
    end

    qte_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_quat  (i_quat),
        .i_full  (fq_full),
        .o_push  (fq_push),
        .o_entry (fq_entry)
    );

    qte_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fq_push),
        .i_entry (fq_entry),
        .o_full  (fq_full),
        .i_pop   (qb_pop),
        .o_entry (qb_entry),
        .o_empty (qb_empty)
    );

    qte_back #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
        .CORDIC_STEPS    (CORDIC_STEPS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_deg   (r_deg),
        .i_entry (qb_entry),
        .i_empty (qb_empty),
        .o_pop   (qb_pop),
        .o_euler (o_euler)
    );
endmodule

// ===== rtl/qte_front.sv =====
// Front end: takes a quaternion word, finds its scale and zero case, hands it to the queue.
`timescale 1ns / 1ps
module qte_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    qte_quat_if.sink           i_quat,
    input  logic               i_full,
    output logic               o_push,
    output qte_pkg::t_qte_entry o_entry
);
    import qte_pkg::*;

    logic                 r_vld;
    logic signed [QW-1:0] r_q [4];
    logic [QW-1:0]        mag [4];
    logic [QW-1:0]        mx01;
    logic [QW-1:0]        mx23;
    logic [QW-1:0]        mx;
    logic [4:0]           msb;

    assign i_quat.ready = !r_vld || !i_full;
    assign o_push       = r_vld && !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_quat.ready) begin
            r_vld <= i_quat.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_quat.ready && i_quat.valid) begin
            r_q[0] <= i_quat.quat_w;
            r_q[1] <= i_quat.quat_x;
            r_q[2] <= i_quat.quat_y;
            r_q[3] <= i_quat.quat_z;
        end
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            mag[i] = r_q[i][QW-1] ? QW'(-r_q[i]) : QW'(r_q[i]);
        end
        mx01 = (mag[0] > mag[1]) ? mag[0] : mag[1];
        mx23 = (mag[2] > mag[3]) ? mag[2] : mag[3];
        mx   = (mx01 > mx23) ? mx01 : mx23;
        msb  = '0;
        for (int b = 0; b < QW; b++) begin
            if (mx[b]) begin
                msb = 5'(b);
            end
        end
    end

    // scale so that the largest magnitude lands in [2^29, 2^30)
    always_comb begin
        o_entry.w    = r_q[0];
        o_entry.x    = r_q[1];
        o_entry.y    = r_q[2];
        o_entry.z    = r_q[3];
        o_entry.rsh  = (msb > 5'd29) ? 2'(msb - 5'd29) : 2'd0;
        o_entry.lsh  = (msb < 5'd29) ? 5'(5'd29 - msb) : 5'd0;
        o_entry.zero = (mx == '0);
    end
endmodule

// ===== rtl/qte_queue.sv =====
// Short word queue between the front end and the arithmetic pipeline.
`timescale 1ns / 1ps
module qte_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  qte_pkg::t_qte_entry i_entry,
    output logic               o_full,
    input  logic               i_pop,
    output qte_pkg::t_qte_entry o_entry,
    output logic               o_empty
);
    import qte_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    t_qte_entry  r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [PW:0]   r_cnt;

    assign o_full  = (r_cnt == (PW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_entry = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full) else $error("word pushed into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty) else $error("word popped from empty queue");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (PW+1)'(QUEUE_DEPTH)) else $error("queue count out of range");
endmodule

// ===== rtl/qte_cordic.sv =====
// Pipelined vectoring CORDIC: atan2(y, x) in Q30 radians, one stage per rotation.
`timescale 1ns / 1ps
module qte_cordic #(
    parameter int STEPS = 24
) (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic signed [qte_pkg::CW-1:0] i_y,
    input  logic signed [qte_pkg::CW-1:0] i_x,
    output logic signed [qte_pkg::ZW-1:0] o_z
);
    import qte_pkg::*;

    localparam int IW = CW + 3;

    logic signed [IW-1:0] x_ext;
    logic signed [IW-1:0] y_ext;
    logic signed [IW-1:0] r_x [0:STEPS-1];
    logic signed [IW-1:0] r_y [0:STEPS-1];
    logic signed [ZW-1:0] r_z [0:STEPS];
    logic                 r_nul [0:STEPS];

    assign x_ext = {{3{i_x[CW-1]}}, i_x};
    assign y_ext = {{3{i_y[CW-1]}}, i_y};

    // left half plane: rotate by pi first
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_nul[0] <= (i_x == '0) && (i_y == '0);
            if (i_x < 0) begin
                r_x[0] <= -x_ext;
                r_y[0] <= -y_ext;
                r_z[0] <= (i_y >= 0) ? PI_Q30 : -PI_Q30;
            end else begin
                r_x[0] <= x_ext;
                r_y[0] <= y_ext;
                r_z[0] <= '0;
            end
        end
    end

    for (genvar g = 0; g < STEPS; g++) begin : g_step
        localparam logic signed [ZW-1:0] ANG = atan_q30(g);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_nul[g+1] <= r_nul[g];
                r_z[g+1]   <= (r_y[g] > 0) ? r_z[g] + ANG : r_z[g] - ANG;
            end
        end
        if (g < STEPS - 1) begin : g_rot
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    if (r_y[g] > 0) begin
                        r_x[g+1] <= r_x[g] + (r_y[g] >>> g);
                        r_y[g+1] <= r_y[g] - (r_x[g] >>> g);
                    end else begin
                        r_x[g+1] <= r_x[g] - (r_y[g] >>> g);
                        r_y[g+1] <= r_y[g] + (r_x[g] >>> g);
                    end
                end
            end
        end
    end

    assign o_z = r_nul[STEPS] ? '0 : r_z[STEPS];
endmodule

// ===== rtl/qte_back.sv =====
// Arithmetic pipeline: scaling, products, pitch sine/cosine, three CORDICs, angle format.
`timescale 1ns / 1ps
module qte_back #(
    parameter int ANGLE_FRAC_BITS = 20,
    parameter int CORDIC_STEPS    = 24
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_deg,
    input  qte_pkg::t_qte_entry i_entry,
    input  logic               i_empty,
    output logic               o_pop,
    qte_euler_if.source        o_euler
);
    import qte_pkg::*;

    localparam int CL      = CORDIC_STEPS + 1;
    localparam int S_ARG   = 4;
    localparam int S_SQRT0 = S_ARG + 1 + DIV_STEPS + 2;
    localparam int DLY     = S_SQRT0 + SQRT_STEPS - 1 - S_ARG;
    localparam int LAST    = S_SQRT0 + SQRT_STEPS + CL;
    localparam int SH_R    = 30 - ANGLE_FRAC_BITS;
    localparam int SH_D    = 54 - ANGLE_FRAC_BITS;
    localparam logic signed [ZW-1:0] RAD_HALF = ZW'(1) <<< (SH_R - 1);
    localparam logic signed [63:0]   DEG_HALF = 64'(1) <<< (SH_D - 1);
    localparam logic signed [63:0]   WRAP     = 64'(360) <<< ANGLE_FRAC_BITS;
    localparam logic [60:0]          ONE_Q60  = 61'(1) << 60;

    function automatic logic signed [NW-1:0] norm(input logic signed [QW-1:0] q,
                                                  input logic [1:0] rsh,
                                                  input logic [4:0] lsh);
        logic [QW-1:0] m;
        m = q[QW-1] ? QW'(-q) : QW'(q);
        m = (m >> rsh) << lsh;
        return q[QW-1] ? -NW'(m) : NW'(m);
    endfunction

    function automatic logic signed [CW-1:0] trunc22(input logic signed [63:0] v);
        logic [63:0] m;
        m = v[63] ? 64'(-v) : 64'(v);
        m = m >> 22;
        return v[63] ? -CW'(m) : CW'(m);
    endfunction

    logic             adv;
    logic [LAST:0]    r_vld;
    logic             r_zero [0:LAST];

    t_qte_entry           r_in;
    logic signed [NW-1:0] r_w, r_x, r_y, r_z;
    logic signed [61:0]   r_ww, r_xx, r_yy, r_zz, r_wx, r_yz, r_wy, r_zx, r_wz, r_xy;
    logic signed [63:0]   r_n2, r_t0, r_t1, r_t2, r_t3, r_t4;
    logic signed [CW-1:0] r_ry, r_rx, r_yy_arg, r_yx_arg;
    logic [31:0]          r_sn_mag, r_sd;
    logic                 r_sn_neg;
    logic [63:0]          t2_mag;

    logic [31:0] r_rem [0:DIV_STEPS-2];
    logic [31:0] r_dvs [0:DIV_STEPS-2];
    logic [30:0] r_quo [0:DIV_STEPS-1];
    logic        r_dneg [0:DIV_STEPS-1];

    logic signed [31:0] r_sg_s;
    logic [30:0]        r_sg_m;
    logic [61:0]        sq_p;
    logic [60:0]        r_sq_n;
    logic signed [31:0] r_sq_s;

    logic [61:0]        r_sn [0:SQRT_STEPS-2];
    logic [61:0]        r_sr [0:SQRT_STEPS-1];
    logic signed [31:0] r_ss [0:SQRT_STEPS-1];

    logic signed [CW-1:0] p_y, p_x;
    logic signed [ZW-1:0] roll_z, pitch_z, yaw_z;
    logic signed [ZW-1:0] r_rd [0:DLY-1];
    logic signed [ZW-1:0] r_yd [0:DLY-1];

    logic signed [ZW-1:0] f_z [3];
    logic signed [64:0]   f_prod [3];
    logic signed [ZW-1:0] r_fz [3];
    logic signed [63:0]   r_fp [3];
    logic signed [AW-1:0] ang [3];

    logic                 r_out_vld;
    logic signed [AW-1:0] r_roll, r_pitch, r_yaw;
    logic                 r_zq;

    assign adv   = !r_out_vld || o_euler.ready;
    assign o_pop = adv && !i_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_vld     <= {r_vld[LAST-1:0], !i_empty};
            r_out_vld <= r_vld[LAST];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_zero[0] <= i_entry.zero;
            for (int i = 1; i <= LAST; i++) begin
                r_zero[i] <= r_zero[i-1];
            end
        end
    end

    // scaling, products, sums, atan2 arguments
    assign t2_mag = r_t2[63] ? 64'(-r_t2) : 64'(r_t2);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_in <= i_entry;
            r_w  <= norm(r_in.w, r_in.rsh, r_in.lsh);
            r_x  <= norm(r_in.x, r_in.rsh, r_in.lsh);
            r_y  <= norm(r_in.y, r_in.rsh, r_in.lsh);
            r_z  <= norm(r_in.z, r_in.rsh, r_in.lsh);
            r_ww <= r_w * r_w;
            r_xx <= r_x * r_x;
            r_yy <= r_y * r_y;
            r_zz <= r_z * r_z;
            r_wx <= r_w * r_x;
            r_yz <= r_y * r_z;
            r_wy <= r_w * r_y;
            r_zx <= r_z * r_x;
            r_wz <= r_w * r_z;
            r_xy <= r_x * r_y;
            r_n2 <= 64'(r_ww) + 64'(r_xx) + 64'(r_yy) + 64'(r_zz);
            r_t0 <= (64'(r_wx) + 64'(r_yz)) <<< 1;
            r_t1 <= 64'(r_ww) + 64'(r_zz) - 64'(r_xx) - 64'(r_yy);
            r_t2 <= (64'(r_wy) - 64'(r_zx)) <<< 1;
            r_t3 <= (64'(r_wz) + 64'(r_xy)) <<< 1;
            r_t4 <= 64'(r_ww) + 64'(r_xx) - 64'(r_yy) - 64'(r_zz);
            r_ry     <= trunc22(r_t0);
            r_rx     <= trunc22(r_t1);
            r_yy_arg <= trunc22(r_t3);
            r_yx_arg <= trunc22(r_t4);
            r_sn_mag <= t2_mag[61:30];
            r_sn_neg <= r_t2[63];
            r_sd     <= r_n2[61:30];
        end
    end

    // pitch sine: restoring division, one quotient bit per stage
    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
        logic [32:0] dv_num;
        logic [31:0] dv_den;
        logic [30:0] dv_quo;
        logic        dv_neg;
        logic        dv_ge;
        if (j == 0) begin : g_first
            assign dv_num = {1'b0, r_sn_mag};
            assign dv_den = r_sd;
            assign dv_quo = '0;
            assign dv_neg = r_sn_neg;
        end else begin : g_next
            assign dv_num = {r_rem[j-1], 1'b0};
            assign dv_den = r_dvs[j-1];
            assign dv_quo = r_quo[j-1];
            assign dv_neg = r_dneg[j-1];
        end
        assign dv_ge = (dv_num >= {1'b0, dv_den});
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_quo[j]  <= {dv_quo[29:0], dv_ge};
                r_dneg[j] <= dv_neg;
            end
        end
        if (j < DIV_STEPS - 1) begin : g_keep
            always_ff @(posedge i_clk) begin
                if (adv) begin
                    r_rem[j] <= dv_ge ? 32'(dv_num - {1'b0, dv_den}) : dv_num[31:0];
                    r_dvs[j] <= dv_den;
                end
            end
        end
    end

    assign sq_p = r_sg_m * r_sg_m;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sg_m <= r_quo[DIV_STEPS-1];
            r_sg_s <= r_dneg[DIV_STEPS-1] ? -32'(r_quo[DIV_STEPS-1])
                                          : 32'(r_quo[DIV_STEPS-1]);
            r_sq_n <= ONE_Q60 - sq_p[60:0];
            r_sq_s <= r_sg_s;
        end
    end

    // pitch cosine: digit-by-digit square root, one result bit per stage
    for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
        localparam logic [61:0] SBIT = 62'(1) << (2 * (SQRT_STEPS - 1 - j));
        logic [61:0]        sq_n_in;
        logic [61:0]        sq_r_in;
        logic signed [31:0] sq_s_in;
        logic [61:0]        trial;
        logic               sq_ge;
        if (j == 0) begin : g_first
            assign sq_n_in = 62'(r_sq_n);
            assign sq_r_in = '0;
            assign sq_s_in = r_sq_s;
        end else begin : g_next
            assign sq_n_in = r_sn[j-1];
            assign sq_r_in = r_sr[j-1];
            assign sq_s_in = r_ss[j-1];
        end
        assign trial = sq_r_in + SBIT;
        assign sq_ge = (sq_n_in >= trial);
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_sr[j] <= sq_ge ? (sq_r_in >> 1) + SBIT : sq_r_in >> 1;
                r_ss[j] <= sq_s_in;
            end
        end
        if (j < SQRT_STEPS - 1) begin : g_keep
            always_ff @(posedge i_clk) begin
                if (adv) begin
                    r_sn[j] <= sq_ge ? sq_n_in - trial : sq_n_in;
                end
            end
        end
    end

    assign p_y = CW'(r_ss[SQRT_STEPS-1]) <<< 8;
    assign p_x = CW'({r_sr[SQRT_STEPS-1][30:0], 8'b0});

    qte_cordic #(.STEPS(CORDIC_STEPS)) u_roll (
        .i_clk (i_clk), .i_en (adv), .i_y (r_ry), .i_x (r_rx), .o_z (roll_z)
    );
    qte_cordic #(.STEPS(CORDIC_STEPS)) u_yaw (
        .i_clk (i_clk), .i_en (adv), .i_y (r_yy_arg), .i_x (r_yx_arg), .o_z (yaw_z)
    );
    qte_cordic #(.STEPS(CORDIC_STEPS)) u_pitch (
        .i_clk (i_clk), .i_en (adv), .i_y (p_y), .i_x (p_x), .o_z (pitch_z)
    );

    // roll and yaw wait for the pitch path
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_rd[0] <= roll_z;
            r_yd[0] <= yaw_z;
            for (int i = 1; i < DLY; i++) begin
                r_rd[i] <= r_rd[i-1];
                r_yd[i] <= r_yd[i-1];
            end
        end
    end

    always_comb begin
        f_z[0] = r_rd[DLY-1];
        f_z[1] = pitch_z;
        f_z[2] = r_yd[DLY-1];
        for (int i = 0; i < 3; i++) begin
            f_prod[i] = f_z[i] * RAD2DEG_Q24;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                r_fz[i] <= f_z[i];
                r_fp[i] <= f_prod[i][63:0];
            end
        end
    end

    always_comb begin
        logic signed [ZW-1:0] rad;
        logic signed [63:0]   deg;
        for (int i = 0; i < 3; i++) begin
            rad = (r_fz[i] + RAD_HALF) >>> SH_R;
            deg = (r_fp[i] + DEG_HALF) >>> SH_D;
            if (deg < 0) begin
                deg = deg + WRAP;
            end
            ang[i] = i_deg ? deg[AW-1:0] : rad[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_roll  <= r_zero[LAST] ? '0 : ang[0];
            r_pitch <= r_zero[LAST] ? '0 : ang[1];
            r_yaw   <= r_zero[LAST] ? '0 : ang[2];
            r_zq    <= r_zero[LAST];
        end
    end

    assign o_euler.valid           = r_out_vld;
    assign o_euler.roll_angle      = r_roll;
    assign o_euler.pitch_angle     = r_pitch;
    assign o_euler.yaw_angle       = r_yaw;
    assign o_euler.zero_quaternion = r_zq;

    a_zero_angles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_zq) |-> (r_roll == '0 && r_pitch == '0 && r_yaw == '0))
        else $error("zero quaternion word with non-zero angles");
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !o_euler.ready) |=> $stable(r_vld))
        else $error("pipeline moved while output stalled");
endmodule

// ===== tb/tb_quaternion_to_euler.sv =====
// Self-checking testbench for quaternion_to_euler: predicted angles compared word by word.
`timescale 1ns / 1ps
module tb_quaternion_to_euler;
    import qte_pkg::*;

    localparam int ANGLE_FRAC = 20;
    localparam int STEPS      = 24;
    localparam int LATENCY    = STEPS + 73;
    localparam int HOLD_LEN   = 300;
    localparam longint PI_FX  = 64'sd3373259426;
    localparam longint R2D_FX = 64'sd961263669;

    typedef struct packed {
        logic signed [AW-1:0] roll;
        logic signed [AW-1:0] pitch;
        logic signed [AW-1:0] yaw;
        logic                 zero;
    } t_angles;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_wr_en = 1'b0;
    logic i_cfg_wr_data = 1'b0;

    qte_quat_if  quat_ch ();
    qte_euler_if euler_ch ();

    quaternion_to_euler u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_quat        (quat_ch.sink),
        .o_euler       (euler_ch.source),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    always #5 i_clk = ~i_clk;

    t_angles angles_due[$];
    bit      deg_mode = 1'b0;
    int      mismatches = 0;
    int      words_in = 0;
    int      words_out = 0;
    int      hold_cycles = 0;
    int      hold_req = 0;
    int      hold_seen = 0;
    longint  atan_tab[30] = '{843314856, 497837829, 263043836, 133525158, 67021686,
                              33543515, 16775850, 8388437, 4194282, 2097149, 1048575,
                              524287, 262143, 131071, 65535, 32767, 16383, 8191, 4095,
                              2047, 1023, 511, 255, 127, 63, 31, 15, 7, 3, 1};

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint trunc_shift(longint v, int s);
        if (v < 0)
            return -((-v) >>> s);
        return v >>> s;
    endfunction

    function automatic longint int_sqrt(longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    function automatic longint vector_angle(longint y, longint x);
        longint acc;
        longint dx;
        longint dy;
        acc = 0;
        if (x == 0 && y == 0)
            return 0;
        if (x < 0) begin
            acc = (y >= 0) ? PI_FX : -PI_FX;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < STEPS; i++) begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (y > 0) begin
                x += dx;
                y -= dy;
                acc += atan_tab[i];
            end else begin
                x -= dx;
                y += dy;
                acc -= atan_tab[i];
            end
        end
        return acc;
    endfunction

    function automatic logic [AW-1:0] scale_angle(longint a);
        longint r;
        if (deg_mode) begin
            r = floor_shift(a * R2D_FX + (64'sd1 <<< (53 - ANGLE_FRAC)), 54 - ANGLE_FRAC);
            if (r < 0)
                r += 64'sd360 <<< ANGLE_FRAC;
        end else begin
            r = floor_shift(a + (64'sd1 <<< (29 - ANGLE_FRAC)), 30 - ANGLE_FRAC);
        end
        return r[AW-1:0];
    endfunction

    function automatic t_angles euler_of(logic signed [QW-1:0] qw, logic signed [QW-1:0] qx,
                                         logic signed [QW-1:0] qy, logic signed [QW-1:0] qz);
        longint  q[4];
        longint  m;
        longint  w, x, y, z, n2, sn, s, c;
        t_angles r;
        q[0] = qw;
        q[1] = qx;
        q[2] = qy;
        q[3] = qz;
        m = 0;
        foreach (q[i])
            if ((q[i] < 0 ? -q[i] : q[i]) > m)
                m = q[i] < 0 ? -q[i] : q[i];
        r = '0;
        if (m == 0) begin
            r.zero = 1'b1;
            return r;
        end
        while (m >= (64'sd1 <<< 30)) begin
            foreach (q[i])
                q[i] = trunc_shift(q[i], 1);
            m = m >>> 1;
        end
        while (m < (64'sd1 <<< 29)) begin
            foreach (q[i])
                q[i] = q[i] * 2;
            m = m * 2;
        end
        w = q[0];
        x = q[1];
        y = q[2];
        z = q[3];
        n2 = w * w + x * x + y * y + z * z;
        sn = trunc_shift(2 * (w * y - z * x), 30);
        s = (sn * (64'sd1 <<< 30)) / (n2 >>> 30);
        if (s > (64'sd1 <<< 30))
            s = 64'sd1 <<< 30;
        if (s < -(64'sd1 <<< 30))
            s = -(64'sd1 <<< 30);
        c = int_sqrt((64'd1 << 60) - longint'(s * s));
        r.roll = scale_angle(vector_angle(trunc_shift(2 * (w * x + y * z), 22),
                                          trunc_shift(w * w + z * z - x * x - y * y, 22)));
        r.pitch = scale_angle(vector_angle(s * 256, c * 256));
        r.yaw = scale_angle(vector_angle(trunc_shift(2 * (w * z + x * y), 22),
                                         trunc_shift(w * w + x * x - y * y - z * z, 22)));
        return r;
    endfunction

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55)
            return 0;
        if (p < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic send_quat(logic signed [QW-1:0] qw, logic signed [QW-1:0] qx,
                             logic signed [QW-1:0] qy, logic signed [QW-1:0] qz, bit gaps);
        int g;
        g = gaps ? gap_len() : 0;
        if (g > 0) begin
            quat_ch.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        quat_ch.valid  <= 1'b1;
        quat_ch.quat_w <= qw;
        quat_ch.quat_x <= qx;
        quat_ch.quat_y <= qy;
        quat_ch.quat_z <= qz;
        @(posedge i_clk);
        while (!quat_ch.ready)
            @(posedge i_clk);
        angles_due.push_back(euler_of(qw, qx, qy, qz));
        words_in++;
    endtask

    task automatic drain_and_idle();
        quat_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (angles_due.size() != 0)
            @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    task automatic write_unit(bit degrees);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= degrees;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        deg_mode = degrees;
    endtask

    // receiver: random stalls, plus a long hold when one is requested
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            euler_ch.ready <= 1'b0;
        end else if (hold_req != hold_seen) begin
            hold_seen      <= hold_req;
            hold_cycles    <= HOLD_LEN;
            euler_ch.ready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles    <= hold_cycles - 1;
            euler_ch.ready <= 1'b0;
        end else begin
            euler_ch.ready <= ($urandom_range(0, 99) < 75);
        end
    end

    always @(posedge i_clk) begin
        t_angles exp_w;
        if (i_rst_n && euler_ch.valid && euler_ch.ready) begin
            words_out++;
            if (angles_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word roll=%0d", euler_ch.roll_angle);
            end else begin
                exp_w = angles_due.pop_front();
                if (euler_ch.roll_angle !== exp_w.roll || euler_ch.pitch_angle !== exp_w.pitch
                    || euler_ch.yaw_angle !== exp_w.yaw
                    || euler_ch.zero_quaternion !== exp_w.zero) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp r=%0d p=%0d y=%0d z=%0d got r=%0d p=%0d y=%0d z=%0d",
                                 exp_w.roll, exp_w.pitch, exp_w.yaw, exp_w.zero,
                                 euler_ch.roll_angle, euler_ch.pitch_angle,
                                 euler_ch.yaw_angle, euler_ch.zero_quaternion);
                end
            end
        end
    end

    task automatic test_directed();
        logic signed [QW-1:0] mx;
        logic signed [QW-1:0] mn;
        logic signed [QW-1:0] one;
        mx  = 32'sh7fffffff;
        mn  = 32'sh80000000;
        one = 32'sh40000000;
        send_quat(0, 0, 0, 0, 0);
        send_quat(one, 0, 0, 0, 0);
        send_quat(mx, mx, mx, mx, 0);
        send_quat(mn, mn, mn, mn, 0);
        send_quat(mn, mx, mn, mx, 0);
        send_quat(0, one, 0, 0, 0);
        send_quat(0, 0, one, 0, 0);
        send_quat(0, 0, 0, one, 0);
        send_quat(one, 0, one, 0, 0);
        send_quat(one, 0, -one, 0, 0);
        send_quat(one, one, one, one, 0);
        send_quat(1, 0, 0, 0, 1);
        send_quat(-1, 1, 0, 0, 1);
        send_quat(0, -1, 0, 0, 1);
        send_quat(0, 0, 0, -1, 1);
        send_quat(0, 1, 0, 0, 1);
        send_quat(-one, 1, 0, 0, 1);
        send_quat(-one, -1, 0, 0, 1);
        send_quat(0, 0, 1, 1, 1);
        send_quat(mx, 0, 0, mn, 1);
        send_quat(3, 5, -7, 11, 1);
        send_quat(0, 0, 0, 0, 1);
    endtask

    task automatic test_random(int n);
        logic signed [QW-1:0] c[4];
        int sh;
        for (int k = 0; k < n; k++) begin
            sh = $urandom_range(0, 31);
            foreach (c[i]) begin
                c[i] = $urandom();
                if ($urandom_range(0, 3) == 0)
                    c[i] = c[i] >>> sh;
                if ($urandom_range(0, 9) == 0)
                    c[i] = '0;
            end
            if ($urandom_range(0, 49) == 0)
                c = '{default: '0};
            send_quat(c[0], c[1], c[2], c[3], 1);
        end
    endtask

    // enough words to fill the whole pipeline and the queue during the hold
    task automatic test_backpressure();
        hold_req++;
        for (int k = 0; k < 200; k++)
            send_quat($urandom(), $urandom(), $urandom(), $urandom(), 0);
    endtask

    initial begin
        quat_ch.valid  = 1'b0;
        quat_ch.quat_w = '0;
        quat_ch.quat_x = '0;
        quat_ch.quat_y = '0;
        quat_ch.quat_z = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        drain_and_idle();
        write_unit(1'b1);
        test_directed();
        test_random(500);
        drain_and_idle();
        write_unit(1'b0);
        test_random(500);
        test_backpressure();
        drain_and_idle();
        write_unit(1'b1);
        test_random(500);
        drain_and_idle();
        $display("Covered %0d words in, %0d out, both angle units, zero and extreme inputs,",
                 words_in, words_out);
        $display("random stalls and a long output hold; mismatches: %0d", mismatches);
        if (mismatches == 0 && angles_due.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #5ms;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule
